@@ hw/rtl/rne_pkg.sv @@
// Shared types and constants for the Roman numeral encoder.
// Microcode word layout, opcodes, ASCII letter codes. No dependencies.
package rne_pkg;

    localparam int unsigned VALUE_W  = 12;
    localparam int unsigned LETTER_W = 7;
    localparam int unsigned PC_W     = 5;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 12'd4000;

    localparam logic [LETTER_W-1:0] LTR_NONE = 7'h00;
    localparam logic [LETTER_W-1:0] LTR_M    = 7'h4D;
    localparam logic [LETTER_W-1:0] LTR_D    = 7'h44;
    localparam logic [LETTER_W-1:0] LTR_C    = 7'h43;
    localparam logic [LETTER_W-1:0] LTR_L    = 7'h4C;
    localparam logic [LETTER_W-1:0] LTR_X    = 7'h58;
    localparam logic [LETTER_W-1:0] LTR_V    = 7'h56;
    localparam logic [LETTER_W-1:0] LTR_I    = 7'h49;

    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_START = 5'd0;
    localparam t_pc PC_ERR   = 5'd19;

    // CMP1: remainder >= weight -> emit letter, subtract, stay; else jump.
    // CMP2: remainder >= weight -> emit letter, subtract, fall through to
    //       the EMIT of the second letter; else jump.
    // EMIT: emit letter unconditionally, then jump.
    // ERR:  emit the out-of-range transaction.
    typedef enum logic [1:0] {
        OP_CMP1,
        OP_CMP2,
        OP_EMIT,
        OP_ERR
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [VALUE_W-1:0]   weight;
        logic [LETTER_W-1:0]  letter;
        t_pc                  target;
    } t_uword;

endpackage

@@ hw/rtl/rne_if.sv @@
// Valid/ready channel interfaces for the Roman numeral encoder.
// Depends on rne_pkg for field widths.
interface rne_in_if import rne_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rne_out_if import rne_pkg::*;;
    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                out_of_range;

    modport source (output valid, output letter, output last, output out_of_range,
                    input ready);
    modport sink   (input valid, input letter, input last, input out_of_range,
                    output ready);
endinterface

@@ hw/rtl/roman_numeral_encoder_core.sv @@
// Roman numeral encoder: 12-bit value in, one ASCII numeral letter per output transaction.
// The first letter reaches the output register after the accepted value has loaded the sequencer.
// The sequencer steps through the microcode: each letter and each failed compare is one step,
// a letter step stalls while the output register is full and not taken, and a new value waits until it is idle.
// Out-of-range values (0, >= 4000) give one flagged transaction.
// Reset (synchronous, active low) idles the sequencer and empties the output register.
module roman_numeral_encoder_core import rne_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rne_in_if.sink           i_in,
    rne_out_if.source        o_out
);

    logic               r_busy, n_busy;
    t_pc                r_pc, n_pc;
    logic [VALUE_W-1:0] r_rem, n_rem;

    logic                r_out_valid;
    logic [LETTER_W-1:0] r_out_letter;
    logic                r_out_last;
    logic                r_out_oor;

    t_uword              w_word;
    logic                w_ge;
    logic [VALUE_W-1:0]  w_diff;
    logic                w_out_free;
    logic                w_emit;
    logic [LETTER_W-1:0] w_letter;
    logic                w_last;
    logic                w_oor;
    logic                w_bad;

    rne_ucode u_ucode (
        .i_pc   (r_pc),
        .o_word (w_word)
    );

    assign w_ge       = r_rem >= w_word.weight;
    assign w_diff     = r_rem - w_word.weight;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_bad      = (i_in.value == '0) || (i_in.value >= VALUE_LIMIT);

    assign i_in.ready = i_rst_n && !r_busy;

    always_comb begin
        n_busy   = r_busy;
        n_pc     = r_pc;
        n_rem    = r_rem;
        w_emit   = 1'b0;
        w_letter = w_word.letter;
        w_last   = 1'b0;
        w_oor    = 1'b0;

        if (r_busy) begin
            case (w_word.op)
                OP_CMP1: begin
                    if (w_ge) begin
                        w_emit = 1'b1;
                        w_last = (w_diff == '0);
                        if (w_out_free) begin
                            n_rem = w_diff;
                            if (w_last) begin
                                n_busy = 1'b0;
                            end
                        end
                    end else begin
                        n_pc = w_word.target;
                    end
                end
                OP_CMP2: begin
                    if (w_ge) begin
                        w_emit = 1'b1;
                        if (w_out_free) begin
                            n_rem = w_diff;
                            n_pc  = r_pc + 1'b1;
                        end
                    end else begin
                        n_pc = w_word.target;
                    end
                end
                OP_EMIT: begin
                    w_emit = 1'b1;
                    w_last = (r_rem == '0);
                    if (w_out_free) begin
                        n_pc = w_word.target;
                        if (w_last) begin
                            n_busy = 1'b0;
                        end
                    end
                end
                default: begin
                    w_emit   = 1'b1;
                    w_letter = LTR_NONE;
                    w_last   = 1'b1;
                    w_oor    = 1'b1;
                    if (w_out_free) begin
                        n_busy = 1'b0;
                    end
                end
            endcase
        end else if (i_in.valid) begin
            n_busy = 1'b1;
            n_rem  = i_in.value;
            n_pc   = w_bad ? PC_ERR : PC_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (w_out_free) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc  <= n_pc;
        r_rem <= n_rem;
        if (w_out_free && w_emit) begin
            r_out_letter <= w_letter;
            r_out_last   <= w_last;
            r_out_oor    <= w_oor;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.letter       = r_out_letter;
    assign o_out.last         = r_out_last;
    assign o_out.out_of_range = r_out_oor;

    // error transaction is always a lone, letterless, final one
    a_oor_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_oor) |-> (r_out_last && r_out_letter == LTR_NONE))
        else $error("out-of-range transaction malformed");

    // an accepted value starts the sequencer
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_busy)
        else $error("sequencer not started on accept");

    // the final letter handed to the output register ends the run
    a_last_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_emit && w_last && w_out_free) |=> !r_busy)
        else $error("sequencer still busy after final letter");

    // sequencer never runs with an empty remainder except to emit a second letter or error
    a_rem_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (w_word.op == OP_CMP1 || w_word.op == OP_CMP2)) |-> (r_rem != '0))
        else $error("compare step with zero remainder");

endmodule

@@ hw/rtl/rne_ucode.sv @@
// Microcode store of the Roman numeral encoder: one control word per step.
// Depends on rne_pkg.
module rne_ucode import rne_pkg::*; (
    input  t_pc    i_pc,
    output t_uword o_word
);

    always_comb begin
        case (i_pc)
            5'd0:    o_word = '{OP_CMP1, 12'd1000, LTR_M, 5'd1};
            5'd1:    o_word = '{OP_CMP2, 12'd900,  LTR_C, 5'd3};
            5'd2:    o_word = '{OP_EMIT, 12'd0,    LTR_M, 5'd3};
            5'd3:    o_word = '{OP_CMP1, 12'd500,  LTR_D, 5'd4};
            5'd4:    o_word = '{OP_CMP2, 12'd400,  LTR_C, 5'd6};
            5'd5:    o_word = '{OP_EMIT, 12'd0,    LTR_D, 5'd6};
            5'd6:    o_word = '{OP_CMP1, 12'd100,  LTR_C, 5'd7};
            5'd7:    o_word = '{OP_CMP2, 12'd90,   LTR_X, 5'd9};
            5'd8:    o_word = '{OP_EMIT, 12'd0,    LTR_C, 5'd9};
            5'd9:    o_word = '{OP_CMP1, 12'd50,   LTR_L, 5'd10};
            5'd10:   o_word = '{OP_CMP2, 12'd40,   LTR_X, 5'd12};
            5'd11:   o_word = '{OP_EMIT, 12'd0,    LTR_L, 5'd12};
            5'd12:   o_word = '{OP_CMP1, 12'd10,   LTR_X, 5'd13};
            5'd13:   o_word = '{OP_CMP2, 12'd9,    LTR_I, 5'd15};
            5'd14:   o_word = '{OP_EMIT, 12'd0,    LTR_X, 5'd15};
            5'd15:   o_word = '{OP_CMP1, 12'd5,    LTR_V, 5'd16};
            5'd16:   o_word = '{OP_CMP2, 12'd4,    LTR_I, 5'd18};
            5'd17:   o_word = '{OP_EMIT, 12'd0,    LTR_V, 5'd18};
            5'd18:   o_word = '{OP_CMP1, 12'd1,    LTR_I, 5'd18};
            default: o_word = '{OP_ERR,  12'd0,    LTR_NONE, PC_ERR};
        endcase
    end

endmodule
